/* sv/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, reset values and the sequencer microcode of the scalar
// Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int DATA_W      = 32;
   localparam int CHAN_W      = 2;
   localparam int CSR_INDEX_W = 4;

   localparam logic [DATA_W-1:0] Q_NOISE_RESET = 32'd655;
   localparam logic [DATA_W-1:0] R_NOISE_RESET = 32'd65536;

   // datapath operations
   localparam logic [3:0] OP_FETCH    = 4'd0;
   localparam logic [3:0] OP_PRED     = 4'd1;
   localparam logic [3:0] OP_DIV_INIT = 4'd2;
   localparam logic [3:0] OP_DIV_STEP = 4'd3;
   localparam logic [3:0] OP_MUL_GAIN = 4'd4;
   localparam logic [3:0] OP_X_UPD    = 4'd5;
   localparam logic [3:0] OP_MUL_COV  = 4'd6;
   localparam logic [3:0] OP_P_UPD    = 4'd7;
   localparam logic [3:0] OP_EMIT     = 4'd8;

   // conditions that keep the sequencer on the current step
   localparam logic [1:0] HOLD_NONE     = 2'd0;
   localparam logic [1:0] HOLD_NO_REQ   = 2'd1;
   localparam logic [1:0] HOLD_OUT_BUSY = 2'd2;

   // jump conditions
   localparam logic [1:0] JMP_NONE    = 2'd0;
   localparam logic [1:0] JMP_INVALID = 2'd1;
   localparam logic [1:0] JMP_LOOP    = 2'd2;
   localparam logic [1:0] JMP_ALWAYS  = 2'd3;

   localparam int STEPS = 9;
   localparam int PC_W  = $clog2(STEPS);

   localparam logic [PC_W-1:0] STEP_FETCH = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_DIV   = PC_W'(3);
   localparam logic [PC_W-1:0] STEP_EMIT  = PC_W'(8);
   localparam logic [PC_W-1:0] STEP_NEXT  = PC_W'(0);

   typedef struct packed {
      logic [3:0]      op;
      logic [1:0]      hold;
      logic [1:0]      jump;
      logic [PC_W-1:0] target;
   } uword_type;

   localparam uword_type UCODE [STEPS] = '{
      '{OP_FETCH,    HOLD_NO_REQ,   JMP_NONE,    STEP_NEXT},
      '{OP_PRED,     HOLD_NONE,     JMP_INVALID, STEP_EMIT},
      '{OP_DIV_INIT, HOLD_NONE,     JMP_NONE,    STEP_NEXT},
      '{OP_DIV_STEP, HOLD_NONE,     JMP_LOOP,    STEP_DIV},
      '{OP_MUL_GAIN, HOLD_NONE,     JMP_NONE,    STEP_NEXT},
      '{OP_X_UPD,    HOLD_NONE,     JMP_NONE,    STEP_NEXT},
      '{OP_MUL_COV,  HOLD_NONE,     JMP_NONE,    STEP_NEXT},
      '{OP_P_UPD,    HOLD_NONE,     JMP_NONE,    STEP_NEXT},
      '{OP_EMIT,     HOLD_OUT_BUSY, JMP_ALWAYS,  STEP_FETCH}
   };

endpackage

/* sv/scalar_kalman_filter_multichannel.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter_multichannel
// Scalar Kalman filter over several sensor channels, Q16.16 fixed point,
// driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Each request word carries a channel number and a signed measurement; the
// response word echoes the channel and returns the updated estimate (zero and
// no state change for channel 0 or a channel above CHANNELS). One word is in
// work at a time. A valid channel runs the full update from acceptance to the
// response register, the restoring gain divider retiring one quotient bit per
// cycle over FRAC_BITS + 1 steps; an invalid channel jumps from the prediction
// step straight to the emit step. The response sits in its own register, so
// the next request is taken while the previous response is still waiting.
// Noise registers are written through the csr port; indices at or above
// 2*CHANNELS are ignored.
module scalar_kalman_filter_multichannel #(
   parameter int CHANNELS  = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [skf_pkg::CHAN_W-1:0]           req_channel,
   input  logic signed [skf_pkg::DATA_W-1:0]    req_measurement,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [skf_pkg::CHAN_W-1:0]           rsp_channel_out,
   output logic signed [skf_pkg::DATA_W-1:0]    rsp_estimate,
   input  logic                                 csr_we,
   input  logic [skf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [skf_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int GAIN_W   = FRAC_BITS + 1;
   localparam int PROD_W   = GAIN_W + 1 + skf_pkg::DATA_W + 1;
   localparam int CNT_W    = $clog2(FRAC_BITS + 1);
   localparam int DW       = skf_pkg::DATA_W;

   localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [PROD_W-1:0] HALF =
      {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic [CH_IDX_W+1:0] CHAN_MAX = (CH_IDX_W+2)'(CHANNELS);
   localparam logic [skf_pkg::CSR_INDEX_W:0] CSR_REGS =
      (skf_pkg::CSR_INDEX_W+1)'(2*CHANNELS);

   // sequencer
   logic [skf_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   skf_pkg::uword_type       uword;
   logic                     hold, take, fire;

   // working registers
   logic [skf_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic [CH_IDX_W-1:0]        ch_idx_ff, ch_idx_in;
   logic                       ch_ok_ff, ch_ok_in;
   logic signed [DW-1:0]       z_ff, z_in;
   logic signed [DW-1:0]       x_cur_ff, x_cur_in;
   logic [DW-1:0]              p_cur_ff, p_cur_in;
   logic [DW-1:0]              q_cur_ff, q_cur_in;
   logic [DW-1:0]              r_cur_ff, r_cur_in;
   logic [DW-1:0]              pp_ff, pp_in;
   logic [DW:0]                den_ff, den_in;
   logic [DW+1:0]              rem_ff, rem_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic signed [PROD_W-1:0]   mul_ff, mul_in;
   logic signed [DW-1:0]       est_ff, est_in;

   // per-channel state and noise registers
   logic signed [DW-1:0] x_ff [CHANNELS];
   logic signed [DW-1:0] x_in [CHANNELS];
   logic [DW-1:0]        p_ff [CHANNELS];
   logic [DW-1:0]        p_in [CHANNELS];
   logic [DW-1:0]        qn_ff [CHANNELS];
   logic [DW-1:0]        qn_in [CHANNELS];
   logic [DW-1:0]        rn_ff [CHANNELS];
   logic [DW-1:0]        rn_in [CHANNELS];

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [skf_pkg::CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic signed [DW-1:0]       rsp_est_ff, rsp_est_in;

   // datapath helpers
   logic [CH_IDX_W+1:0]      req_idx_wide;
   logic [CH_IDX_W-1:0]      req_idx;
   logic                     req_ok;
   logic [DW:0]              pred_sum;
   logic                     den_zero, div_ge;
   logic [DW+1:0]            rem_sub;
   logic signed [DW:0]       diff;
   logic signed [GAIN_W:0]   mul_a;
   logic signed [DW:0]       mul_b;
   logic signed [PROD_W-1:0] mul_res;
   logic signed [PROD_W-1:0] rnd, shr;
   logic signed [35:0]       delta, xsum;
   logic signed [DW-1:0]     x_new;
   logic [DW-1:0]            p_new;
   logic [CH_IDX_W-1:0]      csr_ch;

   assign uword = skf_pkg::UCODE[pc_ff];

   always_comb begin
      unique case (uword.hold)
         skf_pkg::HOLD_NO_REQ:   hold = !req_valid;
         skf_pkg::HOLD_OUT_BUSY: hold = rsp_valid_ff && !rsp_ready;
         default:                hold = 1'b0;
      endcase
      unique case (uword.jump)
         skf_pkg::JMP_INVALID: take = !ch_ok_ff;
         skf_pkg::JMP_LOOP:    take = (cnt_ff != '0);
         skf_pkg::JMP_ALWAYS:  take = 1'b1;
         default:              take = 1'b0;
      endcase
   end

   assign fire      = !hold;
   assign req_ready = (uword.op == skf_pkg::OP_FETCH);

   assign req_idx_wide = {{CH_IDX_W{1'b0}}, req_channel} - (CH_IDX_W+2)'(1);
   assign req_idx      = req_idx_wide[CH_IDX_W-1:0];
   assign req_ok       = (req_channel != '0) &&
                         ({{CH_IDX_W{1'b0}}, req_channel} <= CHAN_MAX);

   assign pred_sum = {1'b0, p_cur_ff} + {1'b0, q_cur_ff};

   // restoring divider, one gain bit per step
   assign den_zero = (den_ff == '0);
   assign div_ge   = !den_zero && (rem_ff >= {1'b0, den_ff});
   assign rem_sub  = div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   assign diff = $signed({z_ff[DW-1], z_ff}) - $signed({x_cur_ff[DW-1], x_cur_ff});

   // one shared multiplier, gain times innovation or (1 - gain) times covariance
   always_comb begin
      if (uword.op == skf_pkg::OP_MUL_COV) begin
         mul_a = $signed({1'b0, GAIN_ONE - gain_ff});
         mul_b = $signed({1'b0, pp_ff});
      end else begin
         mul_a = $signed({1'b0, gain_ff});
         mul_b = diff;
      end
   end
   assign mul_res = mul_a * mul_b;

   // round to nearest, ties up, shared by both updates
   assign rnd   = mul_ff + HALF;
   assign shr   = rnd >>> FRAC_BITS;
   assign delta = shr[35:0];
   assign xsum  = $signed({{4{x_cur_ff[DW-1]}}, x_cur_ff}) + delta;

   always_comb begin
      if (xsum[35:31] == 5'b00000 || xsum[35:31] == 5'b11111) begin
         x_new = xsum[DW-1:0];
      end else if (xsum[35]) begin
         x_new = {1'b1, {(DW-1){1'b0}}};
      end else begin
         x_new = {1'b0, {(DW-1){1'b1}}};
      end
      p_new = (shr[35:32] != '0) ? '1 : shr[DW-1:0];
   end

   assign csr_ch = csr_index[CH_IDX_W:1];

   always_comb begin
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      ch_idx_in    = ch_idx_ff;
      ch_ok_in     = ch_ok_ff;
      z_in         = z_ff;
      x_cur_in     = x_cur_ff;
      p_cur_in     = p_cur_ff;
      q_cur_in     = q_cur_ff;
      r_cur_in     = r_cur_ff;
      pp_in        = pp_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      gain_in      = gain_ff;
      mul_in       = mul_ff;
      est_in       = est_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      qn_in        = qn_ff;
      rn_in        = rn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_est_in   = rsp_est_ff;

      if (fire) begin
         pc_in = take ? uword.target : pc_ff + skf_pkg::PC_W'(1);
         unique case (uword.op)
            skf_pkg::OP_FETCH: begin
               chan_in  = req_channel;
               ch_ok_in = req_ok;
               z_in     = req_measurement;
               if (req_ok) begin
                  ch_idx_in = req_idx;
                  x_cur_in  = x_ff[req_idx];
                  p_cur_in  = p_ff[req_idx];
                  q_cur_in  = qn_ff[req_idx];
                  r_cur_in  = rn_ff[req_idx];
               end
            end
            skf_pkg::OP_PRED: begin
               pp_in  = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
               est_in = '0;
            end
            skf_pkg::OP_DIV_INIT: begin
               den_in  = {1'b0, pp_ff} + {1'b0, r_cur_ff};
               rem_in  = {2'b00, pp_ff};
               gain_in = '0;
               cnt_in  = CNT_W'(FRAC_BITS);
            end
            skf_pkg::OP_DIV_STEP: begin
               rem_in  = {rem_sub[DW:0], 1'b0};
               gain_in = {gain_ff[GAIN_W-2:0], div_ge};
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
            skf_pkg::OP_MUL_GAIN,
            skf_pkg::OP_MUL_COV: begin
               mul_in = mul_res;
            end
            skf_pkg::OP_X_UPD: begin
               x_in[ch_idx_ff] = x_new;
               est_in          = x_new;
            end
            skf_pkg::OP_P_UPD: begin
               p_in[ch_idx_ff] = p_new;
            end
            skf_pkg::OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_ff;
               rsp_est_in   = est_ff;
            end
            default: begin
               pc_in = skf_pkg::STEP_FETCH;
            end
         endcase
      end

      if (csr_we && ({1'b0, csr_index} < CSR_REGS)) begin
         if (csr_index[0]) begin
            rn_in[csr_ch] = csr_wdata;
         end else begin
            qn_in[csr_ch] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= skf_pkg::STEP_FETCH;
         cnt_ff       <= '0;
         ch_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            x_ff[i]  <= '0;
            p_ff[i]  <= '0;
            qn_ff[i] <= skf_pkg::Q_NOISE_RESET;
            rn_ff[i] <= skf_pkg::R_NOISE_RESET;
         end
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         ch_ok_ff     <= ch_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         qn_ff        <= qn_in;
         rn_ff        <= rn_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      ch_idx_ff   <= ch_idx_in;
      z_ff        <= z_in;
      x_cur_ff    <= x_cur_in;
      p_cur_ff    <= p_cur_in;
      q_cur_ff    <= q_cur_in;
      r_cur_ff    <= r_cur_in;
      pp_ff       <= pp_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      gain_ff     <= gain_in;
      mul_ff      <= mul_in;
      est_ff      <= est_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_est_ff  <= rsp_est_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_chan_ff;
   assign rsp_estimate    = rsp_est_ff;

endmodule

/* bench/tb_scalar_kalman_filter_multichannel.sv */
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter_multichannel
// Self-checking bench for the multichannel scalar Kalman filter. Request words
// go in with random gaps, response words come out under random back-pressure.
// A scoreboard keeps its own per-channel estimate, covariance and noise
// settings, predicts every response in order and compares channel and
// estimate. The noise registers are reprogrammed between phases once the
// filter has drained.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter_multichannel;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH = 3;
   localparam int FRAC = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 180;

   localparam logic [63:0] GAIN_ONE = 64'd1 << FRAC;
   localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);
   localparam longint EST_MAX = 64'sd2147483647;
   localparam longint EST_MIN = -64'sd2147483648;

   localparam logic [skf_pkg::CHAN_W-1:0] CHAN_INVALID = 2'd0;

   typedef enum logic [skf_pkg::CSR_INDEX_W-1:0] {
      REG_Q_CH1    = 4'd0,
      REG_R_CH1    = 4'd1,
      REG_Q_CH2    = 4'd2,
      REG_R_CH2    = 4'd3,
      REG_Q_CH3    = 4'd4,
      REG_R_CH3    = 4'd5,
      REG_SPARE_LO = 4'd6,
      REG_SPARE_HI = 4'd15
   } noise_reg_type;

   typedef struct {
      logic [skf_pkg::CHAN_W-1:0]        channel;
      logic signed [skf_pkg::DATA_W-1:0] estimate;
   } kf_result_type;

   class kalman_scoreboard;
      logic signed [skf_pkg::DATA_W-1:0] est[NUM_CH];
      logic [skf_pkg::DATA_W-1:0]        cov[NUM_CH];
      logic [skf_pkg::DATA_W-1:0]        q_noise[NUM_CH];
      logic [skf_pkg::DATA_W-1:0]        r_noise[NUM_CH];
      kf_result_type                     expected_estimates[$];
      int                                mismatches;

      function new();
         for (int i = 0; i < NUM_CH; i++) begin
            est[i] = '0;
            cov[i] = '0;
            q_noise[i] = skf_pkg::Q_NOISE_RESET;
            r_noise[i] = skf_pkg::R_NOISE_RESET;
         end
         mismatches = 0;
      endfunction

      function void set_noise(logic [skf_pkg::CSR_INDEX_W-1:0] idx,
                              logic [skf_pkg::DATA_W-1:0] val);
         int slot;
         // writes beyond the last channel are dropped
         if (idx < 2 * NUM_CH) begin
            slot = idx >> 1;
            if (idx[0]) r_noise[slot] = val;
            else q_noise[slot] = val;
         end
      endfunction

      function int pending();
         return expected_estimates.size();
      endfunction

      // one filter update per accepted request word on a valid channel
      function void note_request(logic [skf_pkg::CHAN_W-1:0] ch,
                                 logic signed [skf_pkg::DATA_W-1:0] meas);
         int            slot;
         logic [63:0]   pp, den, gain, pnew;
         longint        z, x, prod, delta, xn;
         kf_result_type w;
         w.channel = ch;
         w.estimate = '0;
         if (ch != CHAN_INVALID && ch <= NUM_CH) begin
            slot = ch - 1;
            pp = {32'd0, cov[slot]} + {32'd0, q_noise[slot]};
            if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
            den = pp + {32'd0, r_noise[slot]};
            gain = (den == 0) ? 64'd0 : (pp << FRAC) / den;
            if (gain > GAIN_ONE) gain = GAIN_ONE;
            z = meas;
            x = est[slot];
            prod = longint'(gain) * (z - x);
            // round half towards plus infinity
            delta = (prod + ROUND_HALF) >>> FRAC;
            xn = x + delta;
            if (xn > EST_MAX) xn = EST_MAX;
            if (xn < EST_MIN) xn = EST_MIN;
            est[slot] = xn[31:0];
            pnew = ((GAIN_ONE - gain) * pp + ROUND_HALF) >> FRAC;
            if (pnew > 64'hFFFF_FFFF) pnew = 64'hFFFF_FFFF;
            cov[slot] = pnew[31:0];
            w.estimate = est[slot];
         end
         expected_estimates.push_back(w);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(logic [skf_pkg::CHAN_W-1:0] ch,
                          logic signed [skf_pkg::DATA_W-1:0] estimate);
         kf_result_type w;
         if (expected_estimates.size() == 0) begin
            report_mismatch($sformatf("unexpected word ch %0d est %h", ch, estimate));
         end else begin
            w = expected_estimates.pop_front();
            if (ch !== w.channel || estimate !== w.estimate)
               report_mismatch($sformatf("ch %0d/%0d est %h/%h (got/exp)",
                                         ch, w.channel, estimate, w.estimate));
         end
      endtask
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [skf_pkg::CHAN_W-1:0]        req_channel;
   logic signed [skf_pkg::DATA_W-1:0] req_measurement;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [skf_pkg::CHAN_W-1:0]        rsp_channel_out;
   logic signed [skf_pkg::DATA_W-1:0] rsp_estimate;
   logic                              csr_we;
   logic [skf_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [skf_pkg::DATA_W-1:0]        csr_wdata;

   kalman_scoreboard                  sb;
   bit                                steady;
   int                                idle_count;
   logic signed [skf_pkg::DATA_W-1:0] level[NUM_CH + 1];

   scalar_kalman_filter_multichannel #(
      .CHANNELS  (NUM_CH),
      .FRAC_BITS (FRAC)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel_out (rsp_channel_out),
      .rsp_estimate    (rsp_estimate),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [skf_pkg::DATA_W-1:0] pick_noise();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return skf_pkg::Q_NOISE_RESET;
         3: return skf_pkg::R_NOISE_RESET;
         4, 5: return $urandom_range(0, 1 << 18);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [skf_pkg::CHAN_W-1:0] pick_channel();
      if ($urandom_range(0, 9) == 0) return CHAN_INVALID;
      return skf_pkg::CHAN_W'($urandom_range(1, NUM_CH));
   endfunction

   // extremes, full-range noise, or a drifting level per channel
   function automatic logic signed [skf_pkg::DATA_W-1:0] pick_measurement(
      logic [skf_pkg::CHAN_W-1:0] ch);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return -32'sd1;
         endcase
      end
      if (r < 45) return $urandom;
      if (r > 94) level[ch] = $urandom;
      return level[ch] + $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
   endfunction

   task automatic send_word(logic [skf_pkg::CHAN_W-1:0] ch,
                            logic signed [skf_pkg::DATA_W-1:0] meas);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_measurement <= meas;
      do @(posedge clock); while (!req_ready);
      sb.note_request(ch, meas);
   endtask

   task automatic write_noise_reg(noise_reg_type idx, logic [skf_pkg::DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_noise(idx, val);
   endtask

   task automatic program_noise(
      logic [skf_pkg::DATA_W-1:0] q1, logic [skf_pkg::DATA_W-1:0] r1,
      logic [skf_pkg::DATA_W-1:0] q2, logic [skf_pkg::DATA_W-1:0] r2,
      logic [skf_pkg::DATA_W-1:0] q3, logic [skf_pkg::DATA_W-1:0] r3);
      write_noise_reg(REG_Q_CH1, q1);
      write_noise_reg(REG_R_CH1, r1);
      write_noise_reg(REG_Q_CH2, q2);
      write_noise_reg(REG_R_CH2, r2);
      write_noise_reg(REG_Q_CH3, q3);
      write_noise_reg(REG_R_CH3, r3);
      if ($urandom_range(0, 1))
         write_noise_reg(noise_reg_type'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                         $urandom);
      csr_we <= 1'b0;
   endtask

   // drain the filter before touching the noise registers
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random back-pressure, checks every word taken
   initial begin
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_channel_out, rsp_estimate);
         if (hold > 0) begin
            hold--;
         end else if (steady || $urandom_range(0, 9) < 6) begin
            rsp_ready <= 1'b1;
            hold = steady ? 0 : $urandom_range(0, 8);
         end else begin
            rsp_ready <= 1'b0;
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      sb = new();
      steady = 1'b0;
      for (int i = 0; i <= NUM_CH; i++) level[i] = $urandom;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_channel <= '0;
      req_measurement <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset noise settings, extremes of the measurement
      send_word(CHAN_INVALID, 32'sh7FFF_FFFF);
      send_word(2'd1, 32'sh7FFF_FFFF);
      send_word(2'd1, 32'sh8000_0000);
      send_word(2'd2, 32'sh0000_0000);
      send_word(2'd3, -32'sd1);
      send_word(2'd3, 32'sh0001_0000);
      send_word(CHAN_INVALID, 32'sh8000_0000);
      send_word(2'd2, 32'sh7FFF_FFFF);
      settle();

      // ch1 full gain then zero denominator, ch2 saturated prediction, ch3 unit gain
      program_noise('0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      send_word(2'd1, 32'sd12345 <<< 16);
      send_word(2'd1, -32'sd7 <<< 16);
      send_word(2'd2, 32'sh8000_0000);
      send_word(2'd2, 32'sh7FFF_FFFF);
      send_word(2'd3, 32'sh7FFF_FFFF);
      send_word(2'd3, 32'sh8000_0000);
      send_word(CHAN_INVALID, '0);
      settle();

      // all noise zero: estimate held once the covariance has collapsed
      program_noise('0, '0, '0, '0, '0, '0);
      send_word(2'd3, 32'sd100);
      send_word(2'd2, -32'sd100);
      send_word(2'd2, 32'sd5);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         logic [skf_pkg::CHAN_W-1:0] ch;
         steady = (p == 2 || p == 5);
         if (p == 0)
            program_noise(skf_pkg::Q_NOISE_RESET, skf_pkg::R_NOISE_RESET,
                          skf_pkg::Q_NOISE_RESET, skf_pkg::R_NOISE_RESET,
                          skf_pkg::Q_NOISE_RESET, skf_pkg::R_NOISE_RESET);
         else
            program_noise(pick_noise(), pick_noise(), pick_noise(), pick_noise(),
                          pick_noise(), pick_noise());
         for (int n = 0; n < PHASE_WORDS; n++) begin
            ch = pick_channel();
            send_word(ch, pick_measurement(ch));
         end
         settle();
      end
      steady = 1'b0;

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/skf_pkg.sv
sv/scalar_kalman_filter_multichannel.sv
bench/tb_scalar_kalman_filter_multichannel.sv
